// File: rtl/sosi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sosi_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ST_W        = 3;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [ST_W-1:0] ST_OOR      = 3'd4;
  localparam logic [ST_W-1:0] ST_DUMP     = 3'd5;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd6;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] element;
    logic [CNT_W-1:0]  count;
    logic              last;
  } res_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

// File: rtl/sosi_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed order compare: flipping the sign bits gives an unsigned compare.
module sosi_cmp (
  input  wire logic [sosi_pkg::DATA_W-1:0] a,
  input  wire logic [sosi_pkg::DATA_W-1:0] b,
  output sosi_pkg::cmp_t                   res
);
  import sosi_pkg::*;

  logic [DATA_W-1:0] a_key;
  logic [DATA_W-1:0] b_key;

  assign a_key  = {~a[DATA_W-1], a[DATA_W-2:0]};
  assign b_key  = {~b[DATA_W-1], b[DATA_W-2:0]};
  assign res.lt = a_key < b_key;
  assign res.eq = a == b;

endmodule

`default_nettype wire

// File: rtl/sosi_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Element store: one write port, one read port, registered read data.
module sosi_mem #(
  parameter int unsigned DEPTH = sosi_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(sosi_pkg::CAPACITY_DEF)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [sosi_pkg::DATA_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [sosi_pkg::DATA_W-1:0] rdata
);
  import sosi_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/sosi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: linear search with the shared compare, then shift up/down one entry
// a cycle through the store; dump walks one entry a cycle unless the output stalls.
module sosi_ctrl #(
  parameter int unsigned CAPACITY = sosi_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(sosi_pkg::CAPACITY_DEF),
  parameter int unsigned CW       = $clog2(sosi_pkg::CAPACITY_DEF + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [sosi_pkg::OP_W-1:0]   in_op,
  input  wire logic [sosi_pkg::DATA_W-1:0] in_value,
  input  wire logic [sosi_pkg::POS_W-1:0]  in_pos,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output sosi_pkg::res_t                   res,
  output logic                             mem_we,
  output logic      [AW-1:0]               mem_waddr,
  output logic      [sosi_pkg::DATA_W-1:0] mem_wdata,
  output logic                             mem_re,
  output logic      [AW-1:0]               mem_raddr,
  input  wire logic [sosi_pkg::DATA_W-1:0] mem_rdata,
  output logic      [CW-1:0]               cnt
);
  import sosi_pkg::*;

  localparam int unsigned IW = CW + 1;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SRCH      = 4'd1;
  localparam logic [3:0] S_INS_CHK   = 4'd2;
  localparam logic [3:0] S_SHU       = 4'd3;
  localparam logic [3:0] S_INS_FIN   = 4'd4;
  localparam logic [3:0] S_RM_CHK    = 4'd5;
  localparam logic [3:0] S_SHD       = 4'd6;
  localparam logic [3:0] S_DUMP      = 4'd7;
  localparam logic [3:0] S_DMP_EMPTY = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              flag_r, flag_nxt;  // insert: duplicate; remove: out of range

  logic [CW-1:0] idx_p1, idx_m1, idx_m2, cnt_p1, cnt_m1, pos_p1;
  logic [IW-1:0] idx_p2;
  cmp_t          cmp;

  sosi_cmp u_cmp (
    .a   (mem_rdata),
    .b   (value_r),
    .res (cmp)
  );

  assign idx_p1 = idx_r + CW'(1);
  assign idx_m1 = idx_r - CW'(1);
  assign idx_m2 = idx_r - CW'(2);
  assign idx_p2 = IW'(idx_r) + IW'(2);
  assign cnt_p1 = cnt_r + CW'(1);
  assign cnt_m1 = cnt_r - CW'(1);
  assign pos_p1 = pos_r + CW'(1);
  assign cnt    = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    value_nxt = value_r;
    flag_nxt  = flag_r;
    in_ready  = state_r == S_IDLE;
    res_valid = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    res.count = CNT_W'(cnt_r);
    mem_we    = 1'b0;
    mem_waddr = pos_r[AW-1:0];
    mem_wdata = value_r;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt = in_value;
          idx_nxt   = '0;
          mem_re    = 1'b1;  // entry 0 lands for search or dump
          case (in_op)
            OP_INSERT: begin
              if (cnt_r == '0) begin
                pos_nxt   = '0;
                flag_nxt  = 1'b0;
                state_nxt = S_INS_CHK;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            OP_REMOVE: begin
              flag_nxt  = CNT_W'(in_pos) >= CNT_W'(cnt_r);
              pos_nxt   = CW'(in_pos);
              state_nxt = S_RM_CHK;
            end
            OP_DUMP: begin
              state_nxt = (cnt_r == '0) ? S_DMP_EMPTY : S_DUMP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (cmp.lt) begin
          idx_nxt = idx_p1;
          if (idx_p1 == cnt_r) begin
            pos_nxt   = cnt_r;
            flag_nxt  = 1'b0;
            state_nxt = S_INS_CHK;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_p1[AW-1:0];
          end
        end else begin
          pos_nxt   = idx_r;
          flag_nxt  = cmp.eq;
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (flag_r) begin
          res_valid  = 1'b1;
          res.status = ST_DUP;
          if (res_ready) state_nxt = S_IDLE;
        end else if (cnt_r == CW'(CAPACITY)) begin
          res_valid  = 1'b1;
          res.status = ST_FULL;
          if (res_ready) state_nxt = S_IDLE;
        end else if (pos_r == cnt_r) begin
          res_valid  = 1'b1;
          res.status = ST_INSERTED;
          res.count  = CNT_W'(cnt_p1);
          if (res_ready) begin
            mem_we    = 1'b1;
            cnt_nxt   = cnt_p1;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = cnt_r;
          mem_re    = 1'b1;
          mem_raddr = cnt_m1[AW-1:0];
          state_nxt = S_SHU;
        end
      end
      S_SHU: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        if (idx_m1 == pos_r) begin
          state_nxt = S_INS_FIN;
        end else begin
          idx_nxt   = idx_m1;
          mem_re    = 1'b1;
          mem_raddr = idx_m2[AW-1:0];
        end
      end
      S_INS_FIN: begin
        res_valid  = 1'b1;
        res.status = ST_INSERTED;
        res.count  = CNT_W'(cnt_p1);
        if (res_ready) begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_p1;
          state_nxt = S_IDLE;
        end
      end
      S_RM_CHK: begin
        if (flag_r) begin
          res_valid  = 1'b1;
          res.status = ST_OOR;
          if (res_ready) state_nxt = S_IDLE;
        end else if (pos_p1 == cnt_r) begin
          res_valid  = 1'b1;
          res.status = ST_REMOVED;
          res.count  = CNT_W'(cnt_m1);
          if (res_ready) begin
            cnt_nxt   = cnt_m1;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = pos_r;
          mem_re    = 1'b1;
          mem_raddr = pos_p1[AW-1:0];
          state_nxt = S_SHD;
        end
      end
      S_SHD: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        if (idx_p2 == IW'(cnt_r)) begin
          res_valid  = 1'b1;
          res.status = ST_REMOVED;
          res.count  = CNT_W'(cnt_m1);
          if (res_ready) begin
            cnt_nxt   = cnt_m1;
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;  // hold read data while stalled
            mem_raddr = idx_p1[AW-1:0];
          end
        end else begin
          idx_nxt   = idx_p1;
          mem_re    = 1'b1;
          mem_raddr = idx_p2[AW-1:0];
        end
      end
      S_DUMP: begin
        res_valid   = 1'b1;
        res.status  = ST_DUMP;
        res.element = mem_rdata;
        res.last    = idx_p1 == cnt_r;
        if (res_ready) begin
          if (idx_p1 == cnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            mem_re    = 1'b1;
            mem_raddr = idx_p1[AW-1:0];
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r[AW-1:0];
        end
      end
      S_DMP_EMPTY: begin
        res_valid  = 1'b1;
        res.status = ST_EMPTY;
        res.count  = '0;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    value_r <= value_nxt;
    flag_r  <= flag_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/sorted_set_insert_remove_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata (low bit up)                 tuser         tlast
// in_      in   value[31:0] position[37:32] pad     op[1:0]       -
// out_     out  element[31:0] count[38:32] pad      status[2:0]   last of item
//
// One word at a time: in_tready is high only while the sequencer idles.
// Insert: search to the slot, then shift the tail up one entry a cycle; an append,
// a duplicate or a full set skips the shift. Remove: shift the tail down over the
// removed entry, skipped if out of range; dump: one result word per element.
// Reset (rst_n low, synchronous) empties the set; the store itself is not cleared.
// Output stalls hold the sequencer; the output register lets the next word in.
module sorted_set_insert_remove_unit #(
  parameter int unsigned CAPACITY = sosi_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sosi_pkg::IN_TDATA_W-1:0]  in_tdata,   // value, position
  input  wire logic [sosi_pkg::OP_W-1:0]        in_tuser,   // op
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [sosi_pkg::OUT_TDATA_W-1:0] out_tdata,  // element, count
  output logic      [sosi_pkg::ST_W-1:0]        out_tuser,  // status
  output logic                                  out_tlast
);
  import sosi_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic [CW-1:0]     cnt;

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  sosi_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_value  (in_tdata[DATA_W-1:0]),
    .in_pos    (in_tdata[DATA_W+POS_W-1:DATA_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cnt       (cnt)
  );

  sosi_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // a new result loads when the register is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - DATA_W - CNT_W)'(0), out_res_r.count, out_res_r.element};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

`ifndef SYNTHESIS
  // set never grows past its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(CAPACITY) >= cnt)
    else $error("element count above capacity");

  // a taken insert, remove or dump word leaves the sequencer busy in the cycle after;
  // the unused op code is dropped in place
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == OP_INSERT || in_tuser == OP_REMOVE || in_tuser == OP_DUMP)
    |=> !in_tready)
    else $error("input taken twice in a row");

  // only dump elements carry a nonzero element field
  a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DUMP |-> out_tdata[DATA_W-1:0] == '0)
    else $error("element set on a non-dump result");

  // only dump elements may leave tlast low
  a_last_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == ST_DUMP)
    else $error("tlast low on a single-result operation");
`endif

endmodule

`default_nettype wire

// File: dv/sorted_set_insert_remove_unit_tb.sv
`timescale 1ns / 1ps

// Random and directed checks of the sorted set unit: a shadow copy of the set
// predicts every result word, a monitor compares each accepted word in order.
module sorted_set_insert_remove_unit_tb;
  import sosi_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 330;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 2 * CAP + 40;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // ignored by the unit

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // value[31:0], position[37:32], pad
  logic [OP_W-1:0]        in_tuser;   // op
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // element[31:0], count[38:32], pad
  logic [ST_W-1:0]        out_tuser;  // status
  logic                   out_tlast;

  logic [DATA_W-1:0] held_set[$];       // shadow of the set, ascending
  res_t              expected_words[$]; // words still owed by the unit
  int                mismatches;
  int                quiet_cycles;
  bit                no_idle;           // burst stretch: no gaps, no stalls

  sorted_set_insert_remove_unit #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Applies one accepted word to the shadow set and queues the words it owes.
  function automatic void apply_set_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                                       logic [POS_W-1:0] pos);
    int   slot;
    res_t word;
    slot = 0;
    word = '0;
    word.last = 1'b1;
    case (op)
      OP_INSERT: begin
        while (slot < held_set.size() && $signed(held_set[slot]) < $signed(value)) slot++;
        // duplicate wins over full
        if (slot < held_set.size() && held_set[slot] == value) word.status = ST_DUP;
        else if (held_set.size() >= CAP) word.status = ST_FULL;
        else begin
          held_set.insert(slot, value);
          word.status = ST_INSERTED;
        end
        word.count = CNT_W'(held_set.size());
        expected_words.push_back(word);
      end
      OP_REMOVE: begin
        if (int'(pos) >= held_set.size()) word.status = ST_OOR;
        else begin
          held_set.delete(int'(pos));
          word.status = ST_REMOVED;
        end
        word.count = CNT_W'(held_set.size());
        expected_words.push_back(word);
      end
      OP_DUMP: begin
        if (held_set.size() == 0) begin
          word.status = ST_EMPTY;
          expected_words.push_back(word);
        end else begin
          for (slot = 0; slot < held_set.size(); slot++) begin
            word.status  = ST_DUMP;
            word.element = held_set[slot];
            word.count   = CNT_W'(held_set.size());
            word.last    = (slot == held_set.size() - 1);
            expected_words.push_back(word);
          end
        end
      end
      default: ;  // unused op code: no word owed
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("ERROR @%0t: %s got 'h%0h, expected 'h%0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic check_word();
    res_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word, status", DATA_W'(out_tuser), '0);
    end else begin
      want = expected_words.pop_front();
      if (out_tuser !== want.status)
        report_mismatch("status", DATA_W'(out_tuser), DATA_W'(want.status));
      if (out_tdata[DATA_W-1:0] !== want.element)
        report_mismatch("element", out_tdata[DATA_W-1:0], want.element);
      if (out_tdata[DATA_W+CNT_W-1:DATA_W] !== want.count)
        report_mismatch("count", DATA_W'(out_tdata[DATA_W+CNT_W-1:DATA_W]),
                        DATA_W'(want.count));
      if (out_tlast !== want.last)
        report_mismatch("last", DATA_W'(out_tlast), DATA_W'(want.last));
    end
  endtask

  // Monitor: prediction first, then the check, so both see the same edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid && in_tready)
        apply_set_op(in_tuser, in_tdata[DATA_W-1:0], in_tdata[DATA_W+POS_W-1:DATA_W]);
      if (out_tvalid && out_tready) check_word();
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("sorted_set_insert_remove_unit: mismatch");
        $finish;
      end
    end
  end

  // Result side: random stall ahead of every word.
  initial begin
    int stall;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // tvalid stays up across back-to-back words; it only drops ahead of a gap.
  task automatic send_word(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                           logic [POS_W-1:0] pos);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {(IN_TDATA_W - POS_W - DATA_W)'(0), pos, value};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Unused fields get random content.
  task automatic insert_value(logic [DATA_W-1:0] value);
    send_word(OP_INSERT, value, POS_W'($urandom_range(0, 63)));
  endtask

  task automatic remove_at(logic [POS_W-1:0] pos);
    send_word(OP_REMOVE, $urandom, pos);
  endtask

  task automatic dump_set();
    send_word(OP_DUMP, $urandom, POS_W'($urandom_range(0, 63)));
  endtask

  task automatic send_noise();
    send_word(OP_UNUSED, $urandom, POS_W'($urandom_range(0, 63)));
  endtask

  task automatic test_empty_set();
    no_idle = 1'b0;
    dump_set();            // empty dump
    remove_at(POS_W'(0));  // remove from empty set
    send_noise();
  endtask

  task automatic test_fill_and_overflow();
    int fill_vals[16];
    fill_vals = '{0, 32'h7fffffff, 32'h80000000, -1, 1, 100, -100, 32'h80000001,
                  32'h7ffffffe, 5, -5, 32'h12345678, -32'sh12345678, 42, -42, 7};
    no_idle = 1'b1;
    for (int i = 0; i < 16; i++) begin
      insert_value(fill_vals[i]);
      if (i == 6) insert_value(-1);  // duplicate on a partly filled set
    end
    no_idle = 1'b0;
    insert_value(32'd77);            // set is full
    insert_value(32'h7fffffff);      // duplicate on a full set
    dump_set();
  endtask

  task automatic test_remove_edges();
    remove_at(POS_W'(CAP - 1));  // largest element
    remove_at(POS_W'(CAP - 1));  // now one past the end
    remove_at(POS_W'(0));        // smallest element
    dump_set();
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return DATA_W'($urandom_range(0, 48) - 24);  // narrow pool, many dups
    if (roll < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h80000000;
        1: return 32'h80000001;
        2: return 32'h7fffffff;
        default: return 32'h7ffffffe;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) != 0) return POS_W'($urandom_range(0, held_set.size()));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Phases grow, shrink, churn or merge (a run of inserts closed by a dump).
  task automatic test_random_mix();
    int sent;
    int phase_len;
    int mode;
    int roll;
    int ins_pct;
    int rem_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(8, 40);
      mode      = $urandom_range(0, 3);
      no_idle   = ($urandom_range(0, 3) == 0);
      case (mode)
        0:       begin ins_pct = 75;  rem_pct = 15; end
        1:       begin ins_pct = 20;  rem_pct = 70; end
        2:       begin ins_pct = 45;  rem_pct = 45; end
        default: begin ins_pct = 100; rem_pct = 0;  end
      endcase
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 31) == 0) send_noise();  // ignored, not counted
        else begin
          if (roll < ins_pct) insert_value(pick_value());
          else if (roll < ins_pct + rem_pct) remove_at(pick_position());
          else dump_set();
          sent++;
        end
      end
      if (mode == 3) begin
        dump_set();
        sent++;
      end
    end
  endtask

  initial begin
    mismatches   = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_set();
    test_fill_and_overflow();
    test_remove_edges();
    test_random_mix();

    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);  // catch stray words
    if (mismatches == 0)
      $display("sorted_set_insert_remove_unit: match");
    else
      $display("sorted_set_insert_remove_unit: mismatch");
    $finish;
  end

endmodule
